>>> src/spmq_pkg.sv
// Package of the strict priority multi-level job queue.
// Holds the field widths, the request opcodes and the result kinds.
// No dependencies; used by every other file of the block.
package spmq_pkg;

  localparam int JOB_W = 16;
  localparam int LVL_W = 2;
  localparam int ATT_W = 4;
  localparam int CNT_W = 5;
  localparam int TOT_W = 7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_POPPED    = 2'd0,
    KIND_PUSH_OK   = 2'd1,
    KIND_PUSH_FULL = 2'd2,
    KIND_COUNT     = 2'd3
  } kind_t;

endpackage

>>> src/strict_priority_multi_queue.sv
// Strict priority multi-level job queue: top level.
// Depends on spmq_pkg and spmq_job_ram.
//
// One FIFO of job identifiers is kept for each priority level, level 0 first.
// The slave channel takes one request per transaction: a push, a pop or a query,
// selected by s_tuser. The master channel returns the results, one transaction
// each, with m_tlast on the final result of a request.
// A push or a query gives one result; the result register is loaded in the EXEC state
// once it is free, and the block then returns to idle for the next request. A pop
// asking for N jobs (N capped at MAX_ATTEMPTS) gives one result per job found, each
// taken from the lowest-numbered non-empty level, and stops once every level is empty;
// each job passes through POP_RD, which chooses the level and reads the job store,
// and then POP_OUT, which loads the result register. A pop that finds nothing gives
// no result.
// The block takes one request at a time; s_tready is high only while it is idle,
// and a new request may be taken while the last result still waits on the master
// channel. When the receiver stalls, the sequencer holds until the result
// register is free, so no result is lost.
// Reset empties every level; the job store itself needs no clearing.
module strict_priority_multi_queue #(
  parameter int LEVELS       = 4,
  parameter int QUEUE_DEPTH  = 16,
  parameter int MAX_ATTEMPTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // job_id [15:0], level [17:16], attempts [21:18], zero fill
  input  logic [1:0]  s_tuser,   // opcode [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_job_id [15:0], out_level [17:16],
                                 // level_count [22:18], total_count [29:23], zero fill
  output logic [1:0]  m_tuser,   // kind [1:0]
  output logic        m_tlast
);

  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int TW    = $clog2(LEVELS * QUEUE_DEPTH + 1);
  localparam int RW    = $clog2(MAX_ATTEMPTS + 1);
  localparam int DEPTH = LEVELS * QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    POP_RD,
    POP_OUT
  } state_t;

  state_t state;

  spmq_pkg::opcode_t          req_op;
  logic [spmq_pkg::JOB_W-1:0] req_job;
  logic [spmq_pkg::LVL_W-1:0] req_lvl;
  logic [spmq_pkg::ATT_W-1:0] req_att;

  logic [PW-1:0] head [LEVELS];
  logic [PW-1:0] tail [LEVELS];
  logic [FW-1:0] fill [LEVELS];
  logic [TW-1:0] total;

  logic [LW-1:0] pop_lvl;
  logic [FW-1:0] pend_cnt;
  logic [TW-1:0] pend_tot;
  logic [RW-1:0] rem;

  spmq_pkg::kind_t            out_kind;
  logic [spmq_pkg::JOB_W-1:0] out_job;
  logic [spmq_pkg::LVL_W-1:0] out_lvl;
  logic [spmq_pkg::CNT_W-1:0] out_cnt;
  logic [spmq_pkg::TOT_W-1:0] out_tot;
  logic                       out_last;

  logic [LW-1:0]              scan;
  logic                       any_job;
  logic [LW-1:0]              sel;
  logic [PW-1:0]              head_sel;
  logic [PW-1:0]              tail_sel;
  logic [FW-1:0]              fill_sel;
  logic [PW-1:0]              head_inc;
  logic [PW-1:0]              tail_inc;
  logic                       lvl_ok;
  logic                       lvl_full;
  logic                       out_free;
  logic                       out_load;
  logic [RW-1:0]              rem_init;
  logic                       wr_en;
  logic                       rd_en;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic [spmq_pkg::JOB_W-1:0] rd_data;

  always_comb begin
    scan    = '0;
    any_job = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (fill[i] != '0) begin
        scan    = LW'(i);
        any_job = 1'b1;
      end
    end
  end

  assign sel      = (state == POP_RD) ? scan : LW'(req_lvl);
  assign head_sel = head[sel];
  assign tail_sel = tail[sel];
  assign fill_sel = fill[sel];
  assign head_inc = (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;
  assign tail_inc = (tail_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_sel + 1'b1;
  assign lvl_ok   = 32'(req_lvl) < 32'(LEVELS);
  assign lvl_full = !lvl_ok || (fill_sel >= FW'(QUEUE_DEPTH));
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free &&
                    (((state == EXEC) && ((req_op == spmq_pkg::OP_PUSH) ||
                                          (req_op == spmq_pkg::OP_QUERY))) ||
                     (state == POP_OUT));
  assign rem_init = (32'(req_att) > 32'(MAX_ATTEMPTS)) ? RW'(MAX_ATTEMPTS) : RW'(req_att);

  assign wr_en   = (state == EXEC) && (req_op == spmq_pkg::OP_PUSH) && out_free && !lvl_full;
  assign rd_en   = (state == POP_RD);
  assign wr_addr = AW'(32'(sel) * QUEUE_DEPTH + 32'(tail_sel));
  assign rd_addr = AW'(32'(sel) * QUEUE_DEPTH + 32'(head_sel));

  spmq_job_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_job_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req_job),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      total    <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            req_op  <= spmq_pkg::opcode_t'(s_tuser);
            req_job <= s_tdata[15:0];
            req_lvl <= s_tdata[17:16];
            req_att <= s_tdata[21:18];
            state   <= EXEC;
          end
        end
        EXEC: begin
          case (req_op)
            spmq_pkg::OP_PUSH: begin
              if (out_free) begin
                m_tvalid <= 1'b1;
                out_job  <= req_job;
                out_lvl  <= req_lvl;
                out_last <= 1'b1;
                if (lvl_full) begin
                  out_kind <= spmq_pkg::KIND_PUSH_FULL;
                  out_cnt  <= lvl_ok ? 5'(fill_sel) : '0;
                  out_tot  <= 7'(total);
                end else begin
                  out_kind  <= spmq_pkg::KIND_PUSH_OK;
                  out_cnt   <= 5'(fill_sel + 1'b1);
                  out_tot   <= 7'(total + 1'b1);
                  tail[sel] <= tail_inc;
                  fill[sel] <= fill_sel + 1'b1;
                  total     <= total + 1'b1;
                end
                state <= IDLE;
              end
            end
            spmq_pkg::OP_POP: begin
              rem <= rem_init;
              if ((rem_init == '0) || !any_job) begin
                state <= IDLE;
              end else begin
                state <= POP_RD;
              end
            end
            spmq_pkg::OP_QUERY: begin
              if (out_free) begin
                m_tvalid <= 1'b1;
                out_kind <= spmq_pkg::KIND_COUNT;
                out_job  <= '0;
                out_lvl  <= req_lvl;
                out_cnt  <= lvl_ok ? 5'(fill_sel) : '0;
                out_tot  <= 7'(total);
                out_last <= 1'b1;
                state    <= IDLE;
              end
            end
            default: begin
              state <= IDLE;
            end
          endcase
        end
        POP_RD: begin
          head[sel] <= head_inc;
          fill[sel] <= fill_sel - 1'b1;
          total     <= total - 1'b1;
          pop_lvl   <= sel;
          pend_cnt  <= fill_sel - 1'b1;
          pend_tot  <= total - 1'b1;
          rem       <= rem - 1'b1;
          state     <= POP_OUT;
        end
        POP_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            out_kind <= spmq_pkg::KIND_POPPED;
            out_job  <= rd_data;
            out_lvl  <= spmq_pkg::LVL_W'(pop_lvl);
            out_cnt  <= 5'(pend_cnt);
            out_tot  <= 7'(pend_tot);
            out_last <= (rem == '0) || (pend_tot == '0);
            if ((rem == '0) || (pend_tot == '0)) begin
              state <= IDLE;
            end else begin
              state <= POP_RD;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == IDLE);
  assign m_tdata  = {2'b00, out_tot, out_cnt, out_lvl, out_job};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  logic [TW-1:0] fill_sum;
  logic          over_fill;

  always_comb begin
    fill_sum  = '0;
    over_fill = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      fill_sum = fill_sum + TW'(fill[i]);
      if (fill[i] > FW'(QUEUE_DEPTH)) begin
        over_fill = 1'b1;
      end
    end
  end

  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    total == fill_sum)
    else $error("total count differs from the sum of the level counts");

  a_no_over_fill: assert property (@(posedge clk) disable iff (rst)
    !over_fill)
    else $error("a level holds more jobs than its depth");

  a_pop_has_job: assert property (@(posedge clk) disable iff (rst)
    (state == POP_RD) |-> (total != '0))
    else $error("pop read started with every level empty");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("a second request was taken while one was in progress");

endmodule

>>> src/spmq_job_ram.sv
// Job identifier store: one write port and one read port with registered read data.
// Depends on spmq_pkg for the job identifier width.
module spmq_job_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [spmq_pkg::JOB_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [spmq_pkg::JOB_W-1:0] rd_data
);

  logic [spmq_pkg::JOB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> test/tb_strict_priority_multi_queue.sv
// Testbench of the strict priority multi-level job queue (strict_priority_multi_queue).
// Drives push, pop and query requests with random idling on both channels, and checks
// each result against its own queue model. Depends on spmq_pkg and the block's RTL.
module tb_strict_priority_multi_queue;

  localparam int LEVELS       = 4;
  localparam int DEPTH        = 16;
  localparam int MAX_ATTEMPTS = 8;
  localparam int RANDOM_ITEMS = 444;
  localparam int CALM_ITEMS   = 60;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  typedef struct {
    logic [1:0]  opcode;
    logic [15:0] job_id;
    logic [1:0]  level;
    logic [3:0]  attempts;
    bit          drain;
    int          gap;
  } request_t;

  typedef struct {
    spmq_pkg::kind_t kind;
    logic [15:0]     job_id;
    logic [1:0]      level;
    logic [4:0]      count;
    logic [6:0]      total;
    logic            last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  request_t pending_requests[$];
  result_t  expected_results[$];
  request_t cur_req;
  bit       req_taken = 1'b0;
  int       send_gap = 0;
  int       stall_left = 0;
  bit       rx_steady = 1'b0;
  int       results_owed = 0;
  int       n_total = 0;
  int       n_accepted = 0;
  int       n_results = 0;
  int       n_popped = 0;
  int       n_refused = 0;
  int       n_errors = 0;
  int       op_count[4] = '{default: 0};
  int       quiet_cycles = 0;

  logic [15:0] model_jobs[LEVELS][DEPTH];
  logic [3:0]  model_head[LEVELS];
  logic [3:0]  model_tail[LEVELS];
  logic [4:0]  model_fill[LEVELS];

  strict_priority_multi_queue u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] model_total();
    logic [6:0] sum;
    sum = '0;
    for (int l = 0; l < LEVELS; l++) sum += 7'(model_fill[l]);
    return sum;
  endfunction

  function automatic logic [3:0] next_slot(input logic [3:0] p);
    return (p == 4'(DEPTH - 1)) ? 4'd0 : p + 4'd1;
  endfunction

  task automatic expect_result(input spmq_pkg::kind_t kind, input logic [15:0] job,
                               input int lv, input logic last);
    result_t r;
    r.kind   = kind;
    r.job_id = job;
    r.level  = lv[1:0];
    r.count  = model_fill[lv];
    r.total  = model_total();
    r.last   = last;
    expected_results.push_back(r);
    results_owed++;
  endtask

  task automatic apply_to_queue_model(input request_t r);
    int lv;
    int left;
    logic [15:0] got;
    lv = int'(r.level);
    case (r.opcode)
      spmq_pkg::OP_PUSH: begin
        if (model_fill[lv] >= 5'(DEPTH)) begin
          expect_result(spmq_pkg::KIND_PUSH_FULL, r.job_id, lv, 1'b1);
        end else begin
          model_jobs[lv][model_tail[lv]] = r.job_id;
          model_tail[lv] = next_slot(model_tail[lv]);
          model_fill[lv]++;
          expect_result(spmq_pkg::KIND_PUSH_OK, r.job_id, lv, 1'b1);
        end
      end
      spmq_pkg::OP_POP: begin
        // Levels only drain during a pop, so the scan never has to look back.
        left = (int'(r.attempts) > MAX_ATTEMPTS) ? MAX_ATTEMPTS : int'(r.attempts);
        lv = 0;
        while (left > 0 && model_total() != 0) begin
          while (model_fill[lv] == 0) lv++;
          got = model_jobs[lv][model_head[lv]];
          model_head[lv] = next_slot(model_head[lv]);
          model_fill[lv]--;
          left--;
          expect_result(spmq_pkg::KIND_POPPED, got, lv, left == 0 || model_total() == 0);
        end
      end
      spmq_pkg::OP_QUERY: begin
        expect_result(spmq_pkg::KIND_COUNT, 16'd0, lv, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_request(input logic [1:0] op, input logic [15:0] job,
                               input logic [1:0] lv, input logic [3:0] att,
                               input bit drain, input int gap);
    request_t r;
    r.opcode   = op;
    r.job_id   = job;
    r.level    = lv;
    r.attempts = att;
    r.drain    = drain;
    r.gap      = gap;
    pending_requests.push_back(r);
    n_total++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // Driver: a request stays on the slave channel until its transaction completes.
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !req_taken)) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].drain && results_owed != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        cur_req = pending_requests.pop_front();
        send_gap = cur_req.gap;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, cur_req.attempts, cur_req.level, cur_req.job_id};
        s_tuser <= cur_req.opcode;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if ($urandom_range(0, 149) == 0) rx_steady = !rx_steady;
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!rx_steady && pending_requests.size() > CALM_ITEMS &&
            $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        model_head[l] = '0;
        model_tail[l] = '0;
        model_fill[l] = '0;
      end
    end else if (s_tvalid && s_tready) begin
      req_taken = 1'b1;
      apply_to_queue_model(cur_req);
      op_count[cur_req.opcode]++;
      n_accepted++;
    end
  end

  // Monitor: every result transaction is matched against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, job %0d", m_tuser, m_tdata[15:0]);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        results_owed--;
        if (want.kind == spmq_pkg::KIND_POPPED) n_popped++;
        if (want.kind == spmq_pkg::KIND_PUSH_FULL) n_refused++;
        check_field("kind", int'(want.kind), int'(m_tuser));
        check_field("out_job_id", int'(want.job_id), int'(m_tdata[15:0]));
        check_field("out_level", int'(want.level), int'(m_tdata[17:16]));
        check_field("level_count", int'(want.count), int'(m_tdata[22:18]));
        check_field("total_count", int'(want.total), int'(m_tdata[29:23]));
        check_field("last", int'(want.last), int'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_strict_priority_multi_queue: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int roll;
    int bias;
    int fav;
    bit gappy;
    logic [1:0] op;
    logic [1:0] lv;
    logic [3:0] att;
    int gap;

    // Directed part: empty queue, ignored opcode, zero and saturated attempts,
    // extreme job identifiers and a level filled past its depth.
    queue_request(spmq_pkg::OP_QUERY, 16'h0000, 2'd0, 4'd0, 1'b0, 0);
    queue_request(spmq_pkg::OP_POP, 16'h0000, 2'd0, 4'd5, 1'b0, 0);
    queue_request(OP_IGNORED, 16'hFFFF, 2'd3, 4'd15, 1'b0, 0);
    queue_request(spmq_pkg::OP_POP, 16'h0000, 2'd0, 4'd0, 1'b0, 0);
    queue_request(spmq_pkg::OP_PUSH, 16'h0000, 2'd0, 4'd0, 1'b0, 0);
    queue_request(spmq_pkg::OP_PUSH, 16'hFFFF, 2'd3, 4'd15, 1'b0, 0);
    queue_request(spmq_pkg::OP_QUERY, 16'hFFFF, 2'd3, 4'd0, 1'b0, 0);
    queue_request(spmq_pkg::OP_POP, 16'h0000, 2'd0, 4'd15, 1'b0, 0);
    for (int k = 0; k <= DEPTH; k++)
      queue_request(spmq_pkg::OP_PUSH, 16'($urandom_range(0, 65535)), 2'd2, 4'd0, 1'b0, 0);
    queue_request(spmq_pkg::OP_POP, 16'h0000, 2'd1, 4'd8, 1'b0, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) begin
        bias = $urandom_range(0, 2);
        fav = $urandom_range(0, LEVELS - 1);
        gappy = $urandom_range(0, 2) != 0;
      end
      roll = $urandom_range(0, 99);
      case (bias)
        0: op = (roll < 75) ? spmq_pkg::OP_PUSH : (roll < 90) ? spmq_pkg::OP_POP :
                (roll < 97) ? spmq_pkg::OP_QUERY : OP_IGNORED;
        1: op = (roll < 30) ? spmq_pkg::OP_PUSH : (roll < 80) ? spmq_pkg::OP_POP :
                (roll < 96) ? spmq_pkg::OP_QUERY : OP_IGNORED;
        default: op = (roll < 50) ? spmq_pkg::OP_PUSH : (roll < 78) ? spmq_pkg::OP_POP :
                      (roll < 96) ? spmq_pkg::OP_QUERY : OP_IGNORED;
      endcase
      lv = ($urandom_range(0, 1) == 0) ? fav[1:0] : 2'($urandom_range(0, LEVELS - 1));
      att = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, MAX_ATTEMPTS)) :
                                         4'($urandom_range(0, 15));
      gap = (gappy && i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) ?
            int'($urandom_range(1, 13)) : 0;
      queue_request(op, 16'($urandom_range(0, 65535)), lv, att, i % 150 == 0, gap);
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    while (n_accepted != n_total || results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d push, %0d pop, %0d query, %0d ignored.",
             n_accepted, op_count[spmq_pkg::OP_PUSH], op_count[spmq_pkg::OP_POP],
             op_count[spmq_pkg::OP_QUERY], op_count[OP_IGNORED]);
    $display("Checked %0d results: %0d jobs popped, %0d pushes refused at a full level.",
             n_results, n_popped, n_refused);
    if (n_errors == 0) begin
      $display("tb_strict_priority_multi_queue: done, clean");
    end else begin
      $display("tb_strict_priority_multi_queue: done, errors");
    end
    $finish;
  end

endmodule
